[design/bdq_pkg.sv]
// ----------------------------------------------------------------------------
// bdq_pkg: shared types and constants for the bounded double-ended queue
// Command codes, count width, defaults and the cell-row control struct.
// ----------------------------------------------------------------------------
package bdq_pkg;

	localparam int CMD_W           = 3;
	localparam int CNT_W           = 7;
	localparam int DEPTH_DEF       = 64;
	localparam int VALUE_WIDTH_DEF = 16;

	localparam logic [CNT_W-1:0] CAP_RESET = 7'd64;

	typedef enum logic [CMD_W-1:0] {
		CMD_PUSH_FRONT = 3'd0,
		CMD_PUSH_BACK  = 3'd1,
		CMD_POP_FRONT  = 3'd2,
		CMD_POP_BACK   = 3'd3,
		CMD_STATUS     = 3'd4
	} cmd_t;

	// Per-row control, shared by every cell of one row
	typedef struct packed {
		logic             shift_up;    // cell i takes cell i-1, cell 0 takes the value
		logic             shift_down;  // cell i takes cell i+1
		logic             write_en;    // cell at wr_index loads the value
		logic [CNT_W-1:0] wr_index;
	} row_ctl_t;

endpackage

[design/bounded_double_ended_queue_core.sv]
// ----------------------------------------------------------------------------
// bounded_double_ended_queue_core: bounded deque, one command per cycle
// Two rows of shifting cells; one has the front at cell 0, the other the rear.
// ----------------------------------------------------------------------------
// A command is taken on any cycle with start high (busy is always low), so one
// command per clock is sustained. Its result appears on the next cycle with
// done high for exactly that cycle and must be captured then: there is no way
// to hold it. Each command is at most one shift or load per row. Capacity is
// written via the cfg port (always ready), values above DEPTH acting as DEPTH;
// the user must write it only while no command is in flight (block does not check).
module bounded_double_ended_queue_core #(
	parameter int DEPTH       = bdq_pkg::DEPTH_DEF,
	parameter int VALUE_WIDTH = bdq_pkg::VALUE_WIDTH_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	output logic                        busy,
	input  logic [bdq_pkg::CMD_W-1:0]   command,
	input  logic [VALUE_WIDTH-1:0]      value,
	input  logic                        cfg_valid,
	output logic                        cfg_ready,
	input  logic [bdq_pkg::CNT_W-1:0]   cfg_data,
	output logic                        done,
	output logic                        success,
	output logic [VALUE_WIDTH-1:0]      front_value,
	output logic [VALUE_WIDTH-1:0]      rear_value,
	output logic                        is_empty,
	output logic                        is_full,
	output logic [bdq_pkg::CNT_W-1:0]   count
);

	localparam int CNT_W = bdq_pkg::CNT_W;
	localparam int DW    = $clog2(DEPTH + 1);
	localparam int CMP_W = (DW > CNT_W) ? DW : CNT_W;

	logic [CNT_W-1:0] cap_q;
	logic [CNT_W-1:0] cap_eff;
	logic [CNT_W-1:0] count_q;
	logic [CNT_W-1:0] count_d;
	logic             done_q;
	logic             success_q;
	logic             full_q;

	logic             accept;
	logic             push_ok;
	logic             pop_ok;
	logic             ok;
	bdq_pkg::cmd_t    cmd;

	bdq_pkg::row_ctl_t fwd_ctl;
	bdq_pkg::row_ctl_t rev_ctl;
	logic [VALUE_WIDTH-1:0] fwd_head;
	logic [VALUE_WIDTH-1:0] rev_head;

	assign busy      = 1'b0;
	assign cfg_ready = 1'b1;
	assign accept    = start && !busy;
	assign cmd       = bdq_pkg::cmd_t'(command);

	assign cap_eff = (CMP_W'(cap_q) > CMP_W'(DEPTH)) ? CNT_W'(DEPTH) : cap_q;
	assign push_ok = (count_q < cap_eff);
	assign pop_ok  = (count_q != '0);

	// Command decode: the fwd row has the front at cell 0, the rev row the rear
	always_comb begin
		fwd_ctl          = '0;
		rev_ctl          = '0;
		fwd_ctl.wr_index = count_q;
		rev_ctl.wr_index = count_q;
		count_d          = count_q;
		ok               = 1'b1;
		unique case (cmd)
			bdq_pkg::CMD_PUSH_FRONT: begin
				ok = push_ok;
				if (accept && push_ok) begin
					fwd_ctl.shift_up = 1'b1;
					rev_ctl.write_en = 1'b1;
					count_d          = count_q + CNT_W'(1);
				end
			end
			bdq_pkg::CMD_PUSH_BACK: begin
				ok = push_ok;
				if (accept && push_ok) begin
					rev_ctl.shift_up = 1'b1;
					fwd_ctl.write_en = 1'b1;
					count_d          = count_q + CNT_W'(1);
				end
			end
			bdq_pkg::CMD_POP_FRONT: begin
				ok = pop_ok;
				if (accept && pop_ok) begin
					fwd_ctl.shift_down = 1'b1;
					count_d            = count_q - CNT_W'(1);
				end
			end
			bdq_pkg::CMD_POP_BACK: begin
				ok = pop_ok;
				if (accept && pop_ok) begin
					rev_ctl.shift_down = 1'b1;
					count_d            = count_q - CNT_W'(1);
				end
			end
			default: begin
				ok = 1'b1;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q     <= bdq_pkg::CAP_RESET;
			count_q   <= '0;
			done_q    <= 1'b0;
			success_q <= 1'b0;
			full_q    <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				cap_q <= cfg_data;
			end
			count_q <= count_d;
			done_q  <= accept;
			if (accept) begin
				success_q <= ok;
				full_q    <= (count_d >= cap_eff);
			end
		end
	end

	bdq_row #(
		.DEPTH       (DEPTH),
		.VALUE_WIDTH (VALUE_WIDTH)
	) u_fwd_row (
		.clk       (clk),
		.ctl       (fwd_ctl),
		.value     (value),
		.head_data (fwd_head)
	);

	bdq_row #(
		.DEPTH       (DEPTH),
		.VALUE_WIDTH (VALUE_WIDTH)
	) u_rev_row (
		.clk       (clk),
		.ctl       (rev_ctl),
		.value     (value),
		.head_data (rev_head)
	);

	assign done        = done_q;
	assign success     = success_q;
	assign is_empty    = (count_q == '0);
	assign is_full     = full_q;
	assign count       = count_q;
	assign front_value = is_empty ? '0 : fwd_head;
	assign rear_value  = is_empty ? '0 : rev_head;

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		CMP_W'(count_q) <= CMP_W'(DEPTH))
		else $error("entry count above depth");

	a_refused_hold: assert property (@(posedge clk) disable iff (!arst_n)
		accept && !ok |=> $stable(count_q))
		else $error("refused command changed the count");

	a_result_follows: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> done)
		else $error("no result after an accepted command");

	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		!accept |=> !done)
		else $error("result without a command");

endmodule

[design/bdq_cell.sv]
// ----------------------------------------------------------------------------
// bdq_cell: one entry of a storage row
// Holds one value and moves it to or takes it from its neighbors.
// ----------------------------------------------------------------------------
module bdq_cell #(
	parameter int VALUE_WIDTH = bdq_pkg::VALUE_WIDTH_DEF,
	parameter int INDEX       = 0
) (
	input  logic                   clk,
	input  bdq_pkg::row_ctl_t      ctl,
	input  logic [VALUE_WIDTH-1:0] value,
	input  logic [VALUE_WIDTH-1:0] left_data,
	input  logic [VALUE_WIDTH-1:0] right_data,
	output logic [VALUE_WIDTH-1:0] data
);

	localparam bit REACHABLE = (INDEX < (1 << bdq_pkg::CNT_W));

	logic [VALUE_WIDTH-1:0] data_q;
	logic [VALUE_WIDTH-1:0] data_d;
	logic                   hit;

	assign hit = REACHABLE && ctl.write_en
		&& (ctl.wr_index == bdq_pkg::CNT_W'(INDEX));

	always_comb begin
		data_d = data_q;
		if (ctl.shift_up) begin
			data_d = (INDEX == 0) ? value : left_data;
		end else if (ctl.shift_down) begin
			data_d = right_data;
		end else if (hit) begin
			data_d = value;
		end
	end

	always_ff @(posedge clk) begin
		data_q <= data_d;
	end

	assign data = data_q;

endmodule

[design/bdq_row.sv]
// ----------------------------------------------------------------------------
// bdq_row: a row of storage cells
// Cell 0 is the end of the queue that this row serves; entries run inward.
// ----------------------------------------------------------------------------
module bdq_row #(
	parameter int DEPTH       = bdq_pkg::DEPTH_DEF,
	parameter int VALUE_WIDTH = bdq_pkg::VALUE_WIDTH_DEF
) (
	input  logic                   clk,
	input  bdq_pkg::row_ctl_t      ctl,
	input  logic [VALUE_WIDTH-1:0] value,
	output logic [VALUE_WIDTH-1:0] head_data
);

	logic [VALUE_WIDTH-1:0] cell_data [DEPTH];

	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		bdq_cell #(
			.VALUE_WIDTH (VALUE_WIDTH),
			.INDEX       (i)
		) u_cell (
			.clk        (clk),
			.ctl        (ctl),
			.value      (value),
			.left_data  ((i == 0) ? value : cell_data[(i == 0) ? 0 : i-1]),
			.right_data (cell_data[(i == DEPTH-1) ? i : i+1]),
			.data       (cell_data[i])
		);
	end

	assign head_data = cell_data[0];

endmodule
